>>> rtl/fjop_pkg.sv
// fjop_pkg: shared types, byte constants and helpers for the flat json object parser
// no dependencies; imported by every rtl module of the block
package fjop_pkg;

  localparam int FJOP_FIFO_DEPTH = 2;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    CL_LBRACE,
    CL_RBRACE,
    CL_COLON,
    CL_COMMA,
    CL_QUOTE,
    CL_BSLASH,
    CL_SPACE,
    CL_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    PH_OPEN      = 4'd0,
    PH_FIRST     = 4'd1,
    PH_KEY       = 4'd2,
    PH_KEY_ESC   = 4'd3,
    PH_COLON     = 4'd4,
    PH_VAL_START = 4'd5,
    PH_VAL       = 4'd6,
    PH_VAL_ESC   = 4'd7,
    PH_SEP       = 4'd8,
    PH_KEY_START = 4'd9,
    PH_ACCEPT    = 4'd10,
    PH_REJECT    = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSE  = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] unesc;
    cls_t       cls;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       char_in_key;
    logic       key_end;
    logic       value_end;
    status_t    status;
  } res_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    case (c)
      CH_LBRACE: k = CL_LBRACE;
      CH_RBRACE: k = CL_RBRACE;
      CH_COLON:  k = CL_COLON;
      CH_COMMA:  k = CL_COMMA;
      CH_QUOTE:  k = CL_QUOTE;
      CH_BSLASH: k = CL_BSLASH;
      default: begin
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) k = CL_SPACE;
        else k = CL_OTHER;
      end
    endcase
    return k;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] u;
    case (c)
      CH_N:    u = CH_LF;
      CH_T:    u = CH_TAB;
      CH_R:    u = CH_CR;
      default: u = c;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/fjop_in_if.sv
// fjop_in_if: byte channel into the parser, valid/ready with message byte and last mark
// no dependencies
interface fjop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

>>> rtl/fjop_out_if.sv
// fjop_out_if: result channel out of the parser, valid/ready with one result per byte
// no dependencies
interface fjop_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_out;
  logic       char_in_key;
  logic       key_end;
  logic       value_end;
  logic [1:0] status;

  modport source (output valid, output char_valid, output char_out, output char_in_key,
                  output key_end, output value_end, output status, input ready);
  modport sink   (input valid, input char_valid, input char_out, input char_in_key,
                  input key_end, input value_end, input status, output ready);
endinterface

>>> rtl/flat_json_object_parser.sv
// flat_json_object_parser: top level, front classifier, token queue and grammar back end
// depends on fjop_pkg, fjop_in_if, fjop_out_if, fjop_front, fjop_fifo, fjop_back
//
//  channel   dir  handshake      payload
//  in_if     in   valid/ready    in_byte[7:0], last
//  out_if    out  valid/ready    char_valid, char_out[7:0], char_in_key, key_end,
//                                value_end, status[1:0]
//
//  one byte accepted per cycle unless out_if stalls, one result per byte, passed on
//  via front register, queue, result register; the grammar step is a 4-bit phase register
//  reset is synchronous active low, clears phase to waiting for opening brace and empties
//  the queue; no clearing pass
//  a stalled result blocks the back end, the queue absorbs up to FIFO_DEPTH tokens, then
//  the front register holds and in_if.ready drops
module flat_json_object_parser
  import fjop_pkg::*;
#(
  parameter int FIFO_DEPTH = FJOP_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  fjop_in_if.sink    in_if,
  fjop_out_if.source out_if
);

  logic push_valid, push_ready;
  tok_t push_tok;
  logic pop_valid, pop_ready;
  tok_t pop_tok;

  fjop_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok)
  );

  fjop_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tok    (pop_tok)
  );

  fjop_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_tok   (pop_tok),
    .out_if    (out_if)
  );

endmodule

>>> rtl/fjop_front.sv
// fjop_front: accepts message bytes, classifies them and registers the token
// depends on fjop_pkg and fjop_in_if
module fjop_front
  import fjop_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  fjop_in_if.sink        in_if,
  output logic           push_valid,
  input  logic           push_ready,
  output tok_t           push_tok
);

  logic vld_r, vld_nxt;
  tok_t tok_r, tok_nxt;

  assign in_if.ready = !vld_r || push_ready;

  always_comb begin
    vld_nxt = vld_r;
    tok_nxt = tok_r;
    if (in_if.ready) begin
      vld_nxt = in_if.valid;
    end
    if (in_if.valid && in_if.ready) begin
      tok_nxt.raw   = in_if.in_byte;
      tok_nxt.unesc = unescape(in_if.in_byte);
      tok_nxt.cls   = classify(in_if.in_byte);
      tok_nxt.last  = in_if.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign push_valid = vld_r;
  assign push_tok   = tok_r;

endmodule

>>> rtl/fjop_fifo.sv
// fjop_fifo: short token queue between front and back
// depends on fjop_pkg
module fjop_fifo
  import fjop_pkg::*;
#(
  parameter int DEPTH = FJOP_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  tok_t push_tok,
  output logic pop_valid,
  input  logic pop_ready,
  output tok_t pop_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_tok    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

>>> rtl/fjop_back.sv
// fjop_back: grammar state machine and registered result stage
// depends on fjop_pkg and fjop_out_if
module fjop_back
  import fjop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  tok_t        pop_tok,
  fjop_out_if.source  out_if
);

  phase_t phase_r, phase_nxt;
  phase_t nx;
  res_t   res_c;
  res_t   res_r, res_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   pop;

  assign pop_ready = !out_vld_r || out_if.ready;
  assign pop       = pop_valid && pop_ready;

  // next phase
  always_comb begin
    nx = phase_r;
    case (phase_r)
      PH_OPEN: begin
        if (pop_tok.cls == CL_LBRACE) nx = PH_FIRST;
        else if (pop_tok.cls != CL_SPACE) nx = PH_REJECT;
      end
      PH_FIRST: begin
        if (pop_tok.cls == CL_RBRACE) nx = PH_ACCEPT;
        else if (pop_tok.cls == CL_QUOTE) nx = PH_KEY;
        else if (pop_tok.cls != CL_SPACE) nx = PH_REJECT;
      end
      PH_KEY: begin
        if (pop_tok.cls == CL_QUOTE) nx = PH_COLON;
        else if (pop_tok.cls == CL_BSLASH) nx = PH_KEY_ESC;
      end
      PH_KEY_ESC: nx = PH_KEY;
      PH_COLON: begin
        if (pop_tok.cls == CL_COLON) nx = PH_VAL_START;
        else if (pop_tok.cls != CL_SPACE) nx = PH_REJECT;
      end
      PH_VAL_START: begin
        if (pop_tok.cls == CL_QUOTE) nx = PH_VAL;
        else if (pop_tok.cls != CL_SPACE) nx = PH_REJECT;
      end
      PH_VAL: begin
        if (pop_tok.cls == CL_QUOTE) nx = PH_SEP;
        else if (pop_tok.cls == CL_BSLASH) nx = PH_VAL_ESC;
      end
      PH_VAL_ESC: nx = PH_VAL;
      PH_SEP: begin
        if (pop_tok.cls == CL_COMMA) nx = PH_KEY_START;
        else if (pop_tok.cls == CL_RBRACE) nx = PH_ACCEPT;
        else if (pop_tok.cls != CL_SPACE) nx = PH_REJECT;
      end
      PH_KEY_START: begin
        if (pop_tok.cls == CL_QUOTE) nx = PH_KEY;
        else if (pop_tok.cls != CL_SPACE) nx = PH_REJECT;
      end
      PH_ACCEPT: nx = PH_ACCEPT;
      default:   nx = PH_REJECT;
    endcase
    phase_nxt = phase_r;
    if (pop) begin
      phase_nxt = pop_tok.last ? PH_OPEN : nx;
    end
  end

  // result fields
  always_comb begin
    res_c = '0;
    case (phase_r)
      PH_KEY: begin
        if (pop_tok.cls == CL_QUOTE) begin
          res_c.key_end = 1'b1;
        end else if (pop_tok.cls != CL_BSLASH) begin
          res_c.char_valid  = 1'b1;
          res_c.char_out    = pop_tok.raw;
          res_c.char_in_key = 1'b1;
        end
      end
      PH_KEY_ESC: begin
        res_c.char_valid  = 1'b1;
        res_c.char_out    = pop_tok.unesc;
        res_c.char_in_key = 1'b1;
      end
      PH_VAL: begin
        if (pop_tok.cls == CL_QUOTE) begin
          res_c.value_end = 1'b1;
        end else if (pop_tok.cls != CL_BSLASH) begin
          res_c.char_valid = 1'b1;
          res_c.char_out   = pop_tok.raw;
        end
      end
      PH_VAL_ESC: begin
        res_c.char_valid = 1'b1;
        res_c.char_out   = pop_tok.unesc;
      end
      default: res_c = '0;
    endcase
    if (nx == PH_ACCEPT) res_c.status = ST_ACCEPT;
    else if (nx == PH_REJECT || pop_tok.last) res_c.status = ST_REJECT;
    else res_c.status = ST_PARSE;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    if (pop) begin
      out_vld_nxt = 1'b1;
      res_nxt     = res_c;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OPEN;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.char_valid  = res_r.char_valid;
  assign out_if.char_out    = res_r.char_out;
  assign out_if.char_in_key = res_r.char_in_key;
  assign out_if.key_end     = res_r.key_end;
  assign out_if.value_end   = res_r.value_end;
  assign out_if.status      = res_r.status;

`ifndef ASSERT_OFF
  // a message end always returns the grammar to the opening brace
  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    pop && pop_tok.last |=> phase_r == PH_OPEN)
    else $error("phase not reset after last byte");

  // a closing quote never carries a string byte
  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.char_valid && (res_r.key_end || res_r.value_end)))
    else $error("string byte on a closing quote");

  // an accept result never carries a string byte
  a_accept_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.status == ST_ACCEPT |-> !res_r.char_valid)
    else $error("string byte on accept");

  // key tag only with a string byte
  a_key_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.char_in_key |-> res_r.char_valid)
    else $error("key tag without a string byte");

  // a result stalled downstream holds the grammar still
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_if.ready |=> $stable(phase_r))
    else $error("phase moved while result stalled");
`endif

endmodule

>>> sim/flat_json_object_parser_tb.sv
// flat_json_object_parser_tb: self-checking bench for the flat json object parser
// drives byte messages through fjop_in_if and checks every result on fjop_out_if
// depends on fjop_pkg, fjop_in_if, fjop_out_if and flat_json_object_parser
`timescale 1ns / 100ps

module flat_json_object_parser_tb
  import fjop_pkg::*;
;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_BYTES = 500;

  // grammar tracker and queue of expected results, one per accepted byte
  class parse_scoreboard;
    phase_t phase = PH_OPEN;
    res_t   expected_results[$];
    int     errors = 0;
    int     messages = 0;
    int     accepted_msgs = 0;
    int     rejected_msgs = 0;
    int     string_bytes = 0;

    function bit is_blank(logic [7:0] b);
      return b inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function logic [7:0] escaped_byte(logic [7:0] b);
      case (b)
        CH_N:    return CH_LF;
        CH_T:    return CH_TAB;
        CH_R:    return CH_CR;
        default: return b;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      res_t   r;
      phase_t nx;
      bit     blank;
      r = '0;
      r.status = ST_PARSE;
      nx = phase;
      blank = is_blank(b);
      case (phase)
        PH_OPEN: begin
          if (b == CH_LBRACE) nx = PH_FIRST;
          else if (!blank) nx = PH_REJECT;
        end
        PH_FIRST: begin
          if (b == CH_RBRACE) nx = PH_ACCEPT;
          else if (b == CH_QUOTE) nx = PH_KEY;
          else if (!blank) nx = PH_REJECT;
        end
        PH_KEY: begin
          if (b == CH_QUOTE) begin
            r.key_end = 1'b1;
            nx = PH_COLON;
          end else if (b == CH_BSLASH) begin
            nx = PH_KEY_ESC;
          end else begin
            r.char_valid  = 1'b1;
            r.char_out    = b;
            r.char_in_key = 1'b1;
          end
        end
        PH_KEY_ESC: begin
          r.char_valid  = 1'b1;
          r.char_out    = escaped_byte(b);
          r.char_in_key = 1'b1;
          nx = PH_KEY;
        end
        PH_COLON: begin
          if (b == CH_COLON) nx = PH_VAL_START;
          else if (!blank) nx = PH_REJECT;
        end
        PH_VAL_START: begin
          if (b == CH_QUOTE) nx = PH_VAL;
          else if (!blank) nx = PH_REJECT;
        end
        PH_VAL: begin
          if (b == CH_QUOTE) begin
            r.value_end = 1'b1;
            nx = PH_SEP;
          end else if (b == CH_BSLASH) begin
            nx = PH_VAL_ESC;
          end else begin
            r.char_valid = 1'b1;
            r.char_out   = b;
          end
        end
        PH_VAL_ESC: begin
          r.char_valid = 1'b1;
          r.char_out   = escaped_byte(b);
          nx = PH_VAL;
        end
        PH_SEP: begin
          if (b == CH_COMMA) nx = PH_KEY_START;
          else if (b == CH_RBRACE) nx = PH_ACCEPT;
          else if (!blank) nx = PH_REJECT;
        end
        PH_KEY_START: begin
          if (b == CH_QUOTE) nx = PH_KEY;
          else if (!blank) nx = PH_REJECT;
        end
        PH_ACCEPT: ;
        default: nx = PH_REJECT;
      endcase

      if (nx == PH_ACCEPT) r.status = ST_ACCEPT;
      else if (nx == PH_REJECT || l) r.status = ST_REJECT;

      if (r.char_valid) string_bytes++;
      if (l) begin
        messages++;
        if (r.status == ST_ACCEPT) accepted_msgs++;
        else rejected_msgs++;
      end
      phase = l ? PH_OPEN : nx;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t exp;
      if (expected_results.size() == 0) begin
        report("result arrived with nothing expected");
        return;
      end
      exp = expected_results.pop_front();
      if (got.char_valid !== exp.char_valid)
        report($sformatf("char_valid %b, expected %b", got.char_valid, exp.char_valid));
      if (got.char_out !== exp.char_out)
        report($sformatf("char_out %h, expected %h", got.char_out, exp.char_out));
      if (got.char_in_key !== exp.char_in_key)
        report($sformatf("char_in_key %b, expected %b", got.char_in_key, exp.char_in_key));
      if (got.key_end !== exp.key_end)
        report($sformatf("key_end %b, expected %b", got.key_end, exp.key_end));
      if (got.value_end !== exp.value_end)
        report($sformatf("value_end %b, expected %b", got.value_end, exp.value_end));
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
    endtask
  endclass

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  fjop_in_if  in_if ();
  fjop_out_if out_if ();

  flat_json_object_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  parse_scoreboard sb = new;

  msg_byte_t  stim[$];
  logic [7:0] msg[$];
  int         sent_count = 0;
  bit         no_idle = 1'b0;
  bit         hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // message building

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endfunction

  function automatic void add_blanks();
    logic [7:0] ws[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    if ($urandom_range(99) < 70) return;
    repeat ($urandom_range(1, 2)) msg.push_back(ws[$urandom_range(5)]);
  endfunction

  function automatic logic [7:0] plain_byte(bit any);
    logic [7:0] b;
    do begin
      b = any ? 8'($urandom_range(255)) : 8'($urandom_range(8'h20, 8'h7E));
    end while (b inside {CH_QUOTE, CH_BSLASH});
    return b;
  endfunction

  function automatic void add_quoted();
    int         pick;
    logic [7:0] esc[5] = '{CH_N, CH_T, CH_R, CH_QUOTE, CH_BSLASH};
    msg.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        msg.push_back(plain_byte(1'b0));
      end else if (pick < 80) begin
        msg.push_back(plain_byte(1'b1));
      end else begin
        msg.push_back(CH_BSLASH);
        if ($urandom_range(3) == 0) msg.push_back(8'($urandom_range(255)));
        else msg.push_back(esc[$urandom_range(4)]);
      end
    end
    msg.push_back(CH_QUOTE);
  endfunction

  function automatic void add_object(bit trailing_comma);
    int pairs;
    pairs = $urandom_range(0, 3);
    if (trailing_comma && pairs == 0) pairs = 1;
    add_blanks();
    msg.push_back(CH_LBRACE);
    add_blanks();
    for (int p = 0; p < pairs; p++) begin
      if (p != 0) begin
        msg.push_back(CH_COMMA);
        add_blanks();
      end
      add_quoted();
      add_blanks();
      msg.push_back(CH_COLON);
      add_blanks();
      add_quoted();
      add_blanks();
    end
    if (trailing_comma) msg.push_back(CH_COMMA);
    msg.push_back(CH_RBRACE);
    // bytes after the closing brace are ignored by the parser
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void flush_message();
    for (int i = 0; i < msg.size(); i++)
      stim.push_back('{data: msg[i], last: (i == msg.size() - 1)});
    msg.delete();
  endfunction

  function automatic void build_stimulus();
    int kind;
    int keep;
    // whitespace, empty object, ignored zero byte after acceptance
    add_text(" {}");
    msg.push_back(8'h00);
    flush_message();
    // all three control escapes, an escaped quote and a high byte
    add_text("{\"\\t\":\"\\n\\r\\\"");
    msg.push_back(8'hFF);
    add_text("\"}");
    flush_message();
    // empty key and value, then a comma right before the brace
    add_text("{\"\":\"\",}");
    flush_message();
    // no opening brace
    add_text("x");
    flush_message();
    // message ends on a backslash
    add_text("{\"\\");
    flush_message();
    // message ends inside a key
    add_text("{\"a");
    flush_message();

    keep = stim.size();
    while (stim.size() < keep + RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        add_object(1'b0);
      end else if (kind < 80) begin
        add_object(1'b0);
        msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
      end else if (kind < 88) begin
        add_object(1'b0);
        kind = $urandom_range(1, msg.size());
        while (msg.size() > kind) void'(msg.pop_back());
      end else if (kind < 92) begin
        add_object(1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(255)));
      end
      flush_message();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.last    <= l;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_byte(b, l);
    sent_count++;
  endtask

  initial begin : byte_source
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    in_if.last    <= 1'b0;
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < stim.size(); i++) begin
      no_idle = (i >= 150 && i < 260);
      send_byte(stim[i].data, stim[i].last);
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d bytes in %0d messages: %0d accepted, %0d rejected",
             sent_count, sb.messages, sb.accepted_msgs, sb.rejected_msgs);
    $display("%0d decoded string bytes checked, %0d mismatches", sb.string_bytes, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    int   stall_left;
    res_t got;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
        got.char_valid  = out_if.char_valid;
        got.char_out    = out_if.char_out;
        got.char_in_key = out_if.char_in_key;
        got.key_end     = out_if.key_end;
        got.value_end   = out_if.value_end;
        got.status      = status_t'(out_if.status);
        sb.check_result(got);
      end
      // one long hold-off so the queue fills and input ready drops
      if (!hold_done && sent_count >= HOLD_AT) begin
        stall_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
